>>> rtl/swrp_pkg.sv
// Shared types and constants for the single-wire reset and presence sequencer.
`timescale 1ns / 1ps
`default_nettype none

package swrp_pkg;

  localparam int unsigned CFG_WIDTH    = 12;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned STATUS_WIDTH = 3;
  localparam int unsigned PHASE_WIDTH  = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_PULSE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POST_PRESENCE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WAIT     = 2'd3;

  // Register reset values
  localparam logic [CFG_WIDTH-1:0] LOW_PULSE_RST     = 12'd480;
  localparam logic [CFG_WIDTH-1:0] SAMPLE_DELAY_RST  = 12'd70;
  localparam logic [CFG_WIDTH-1:0] POST_PRESENCE_RST = 12'd410;
  localparam logic [CFG_WIDTH-1:0] HIGH_WAIT_RST     = 12'd248;

  // Sequencer phases
  localparam logic [PHASE_WIDTH-1:0] PH_IDLE      = 3'd0;
  localparam logic [PHASE_WIDTH-1:0] PH_WAIT_HIGH = 3'd1;
  localparam logic [PHASE_WIDTH-1:0] PH_LOW       = 3'd2;
  localparam logic [PHASE_WIDTH-1:0] PH_SAMPLE    = 3'd3;
  localparam logic [PHASE_WIDTH-1:0] PH_POST      = 3'd4;

  // Reported status codes
  localparam logic [STATUS_WIDTH-1:0] ST_IDLE      = 3'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_WAIT_HIGH = 3'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_LOW       = 3'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_PRESENCE  = 3'd3;
  localparam logic [STATUS_WIDTH-1:0] ST_DONE      = 3'd4;
  localparam logic [STATUS_WIDTH-1:0] ST_NODEV     = 3'd5;

  // One result transaction
  typedef struct packed {
    logic                    drive_low;
    logic [STATUS_WIDTH-1:0] status;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/swrp_step.sv
// Next-phase, timer and result logic for one tick of the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module swrp_step
  import swrp_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 12
) (
  input  wire logic [PHASE_WIDTH-1:0] phase,
  input  wire logic [TIMER_WIDTH-1:0] elapsed,
  input  wire logic                   start_req,
  input  wire logic                   wire_level,
  input  wire logic [CFG_WIDTH-1:0]   low_pulse_ticks,
  input  wire logic [CFG_WIDTH-1:0]   sample_delay_ticks,
  input  wire logic [CFG_WIDTH-1:0]   post_presence_ticks,
  input  wire logic [CFG_WIDTH-1:0]   high_wait_limit,
  output logic      [PHASE_WIDTH-1:0] phase_next,
  output logic      [TIMER_WIDTH-1:0] elapsed_next,
  output res_t                        res
);

  localparam int unsigned LIM_W = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;
  localparam logic [TIMER_WIDTH-1:0] TMAX     = {TIMER_WIDTH{1'b1}};
  localparam logic [LIM_W-1:0]       TMAX_EXT = LIM_W'(TMAX);

  // Limits saturate at the largest timer value
  function automatic logic [TIMER_WIDTH-1:0] clamp(input logic [CFG_WIDTH-1:0] v);
    logic [LIM_W-1:0] ext;
    ext = LIM_W'(v);
    if (ext > TMAX_EXT) begin
      return TMAX;
    end
    return ext[TIMER_WIDTH-1:0];
  endfunction

  logic [PHASE_WIDTH-1:0] ph;
  logic [TIMER_WIDTH-1:0] el;
  logic [TIMER_WIDTH-1:0] el_inc;
  logic [TIMER_WIDTH-1:0] lim_low;
  logic [TIMER_WIDTH-1:0] lim_sample;
  logic [TIMER_WIDTH-1:0] lim_post;
  logic [TIMER_WIDTH-1:0] lim_high;

  assign lim_low    = clamp(low_pulse_ticks);
  assign lim_sample = clamp(sample_delay_ticks);
  assign lim_post   = clamp(post_presence_ticks);
  assign lim_high   = clamp(high_wait_limit);

  // Start in idle is treated as the first wait-high tick
  always_comb begin
    if (phase == PH_IDLE && start_req) begin
      ph = PH_WAIT_HIGH;
      el = '0;
    end else begin
      ph = phase;
      el = elapsed;
    end
  end

  assign el_inc = (el == TMAX) ? el : el + TIMER_WIDTH'(1);

  always_comb begin
    phase_next    = PH_IDLE;
    elapsed_next  = '0;
    res.drive_low = 1'b0;
    res.status    = ST_IDLE;
    unique case (ph)
      PH_WAIT_HIGH: begin
        if (wire_level) begin
          phase_next    = PH_LOW;
          res.drive_low = 1'b1;
          res.status    = ST_LOW;
        end else if (el_inc >= lim_high) begin
          res.status = ST_NODEV;
        end else begin
          phase_next   = PH_WAIT_HIGH;
          elapsed_next = el_inc;
          res.status   = ST_WAIT_HIGH;
        end
      end
      PH_LOW: begin
        if (el_inc >= lim_low) begin
          phase_next = PH_SAMPLE;
          res.status = ST_PRESENCE;
        end else begin
          phase_next    = PH_LOW;
          elapsed_next  = el_inc;
          res.drive_low = 1'b1;
          res.status    = ST_LOW;
        end
      end
      PH_SAMPLE: begin
        if (el_inc >= lim_sample) begin
          // Low line at the sample point means a device answered
          if (!wire_level) begin
            phase_next = PH_POST;
            res.status = ST_PRESENCE;
          end else begin
            res.status = ST_NODEV;
          end
        end else begin
          phase_next   = PH_SAMPLE;
          elapsed_next = el_inc;
          res.status   = ST_PRESENCE;
        end
      end
      PH_POST: begin
        if (el >= lim_post) begin
          res.status = ST_DONE;
        end else begin
          phase_next   = PH_POST;
          elapsed_next = el_inc;
          res.status   = ST_PRESENCE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/swrp_skid.sv
// Two-entry output buffer: result register plus skid register.
`timescale 1ns / 1ps
`default_nettype none

module swrp_skid
  import swrp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire res_t push_data,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      out_data
);

  logic skid_valid;
  res_t skid_data;
  logic pop;

  assign full = skid_valid;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || (pop && !skid_valid)) begin
      out_data <= push_data;
    end else if (pop) begin
      out_data <= skid_data;
    end
    if (out_valid && !pop && push) begin
      skid_data <= push_data;
    end
  end

  // Skid entry is only ever filled behind a held result
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry valid with empty result register");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && skid_valid |=> skid_valid && $stable(out_data))
    else $error("held result changed while stalled and full");
  assert property (@(posedge clk) disable iff (rst) pop && skid_valid |=> out_valid)
    else $error("skid entry lost on drain");

endmodule

`default_nettype wire

>>> rtl/single_wire_reset_presence_core.sv
// Top level of the single-wire bus reset and presence sequencer.
//
//   channel  dir  handshake               payload
//   input    in   in_valid / in_stall     start_req, wire_level
//   output   out  out_valid / out_stall   drive_low, status
//   config   in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each input transaction is one microsecond tick and yields exactly one
// output transaction, registered in the output buffer when the tick is taken.
// One tick per clock sustained while in_stall is low: phase and timer update on each accepted tick.
// Reset (rst, synchronous) returns to idle with the timer at zero and the
// timing registers at their defaults (480, 70, 410, 248 ticks).
// The output side has a result register and a skid register, so a stalled
// result still lets one more tick in; in_stall rises only when both are full.
// cfg_ready is always high; the user must write registers only while the sequencer idles (not enforced).
`timescale 1ns / 1ps
`default_nettype none

module single_wire_reset_presence_core
  import swrp_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 12
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // tick input
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    start_req,
  input  wire logic                    wire_level,
  // result output
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         drive_low,
  output logic      [STATUS_WIDTH-1:0] status,
  // configuration writes
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_WIDTH-1:0]    cfg_data
);

  // Timing registers
  logic [CFG_WIDTH-1:0] low_pulse_ticks;
  logic [CFG_WIDTH-1:0] sample_delay_ticks;
  logic [CFG_WIDTH-1:0] post_presence_ticks;
  logic [CFG_WIDTH-1:0] high_wait_limit;

  // Sequencer state
  logic [PHASE_WIDTH-1:0] phase;
  logic [PHASE_WIDTH-1:0] phase_next;
  logic [TIMER_WIDTH-1:0] elapsed;
  logic [TIMER_WIDTH-1:0] elapsed_next;

  logic accept;
  res_t res;
  res_t out_data;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_pulse_ticks     <= LOW_PULSE_RST;
      sample_delay_ticks  <= SAMPLE_DELAY_RST;
      post_presence_ticks <= POST_PRESENCE_RST;
      high_wait_limit     <= HIGH_WAIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOW_PULSE:     low_pulse_ticks     <= cfg_data;
        CFG_SAMPLE_DELAY:  sample_delay_ticks  <= cfg_data;
        CFG_POST_PRESENCE: post_presence_ticks <= cfg_data;
        CFG_HIGH_WAIT:     high_wait_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // State advances once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      elapsed <= '0;
    end else if (accept) begin
      phase   <= phase_next;
      elapsed <= elapsed_next;
    end
  end

  swrp_step #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .phase               (phase),
    .elapsed             (elapsed),
    .start_req           (start_req),
    .wire_level          (wire_level),
    .low_pulse_ticks     (low_pulse_ticks),
    .sample_delay_ticks  (sample_delay_ticks),
    .post_presence_ticks (post_presence_ticks),
    .high_wait_limit     (high_wait_limit),
    .phase_next          (phase_next),
    .elapsed_next        (elapsed_next),
    .res                 (res)
  );

  swrp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign drive_low = out_data.drive_low;
  assign status    = out_data.status;

  // Every way back to idle also clears the timer
  assert property (@(posedge clk) disable iff (rst) phase == PH_IDLE |-> elapsed == '0)
    else $error("timer nonzero in idle");
  // No tick taken, no state change
  assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase) && $stable(elapsed))
    else $error("state moved without a tick");
  // High line while waiting starts the low pulse
  assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_WAIT_HIGH && wire_level |=> phase == PH_LOW && elapsed == '0)
    else $error("wire high did not start low pulse");
  // A tick always lands in the output buffer
  assert property (@(posedge clk) disable iff (rst) accept |=> out_valid)
    else $error("accepted tick produced no result");

endmodule

`default_nettype wire
